[rtl/swaf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// swaf_pkg
// Shared constants, codes and types of the sliding window anagram finder.
// ----------------------------------------------------------------------------
package swaf_pkg;

  localparam int ALPHABET      = 26;
  localparam int PATTERN_MAX   = 64;
  localparam int POSITION_BITS = 16;

  localparam int LETTER_W = 5;
  localparam int SYM_W    = $clog2(ALPHABET);
  localparam int CNT_W    = $clog2(PATTERN_MAX + 1);
  localparam int RING_AW  = $clog2(PATTERN_MAX);
  localparam int AGREE_W  = $clog2(ALPHABET + 1);

  typedef logic [LETTER_W-1:0]      letter_t;
  typedef logic [SYM_W-1:0]         sym_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [RING_AW-1:0]       ring_addr_t;
  typedef logic [AGREE_W-1:0]       agree_t;
  typedef logic [POSITION_BITS-1:0] pos_t;

  localparam pos_t POS_MAX = '1;

  // Action codes of an input item.
  localparam logic [1:0] ACT_CLEAR   = 2'd0;
  localparam logic [1:0] ACT_PATTERN = 2'd1;
  localparam logic [1:0] ACT_TEXT    = 2'd2;

  // Status codes of a result item.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_PAT_FULL   = 2'd1;
  localparam logic [1:0] ST_PAT_LATE   = 2'd2;
  localparam logic [1:0] ST_POS_SAT    = 2'd3;

  // What an item does to the count memories once it reaches write-back.
  typedef enum logic [1:0] {
    OP_NONE,
    OP_CLEAR,
    OP_PATTERN,
    OP_TEXT
  } op_t;

  // One count memory entry of the pattern side: pattern count and the
  // running count of letters that left the window.
  typedef struct packed {
    cnt_t pat;
    cnt_t rem;
  } pat_rem_t;

  typedef struct packed {
    logic en;
    sym_t addr0;
    sym_t addr1;
  } count_rd_t;

  typedef struct packed {
    logic     clr;
    logic     add_we;
    sym_t     add_addr;
    cnt_t     add_data;
    logic     pr_we;
    sym_t     pr_addr;
    pat_rem_t pr_data;
  } count_wr_t;

endpackage
`default_nettype wire

[rtl/swaf_letter_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// swaf_letter_if
// Input channel: one action and one letter code per transfer.
// ----------------------------------------------------------------------------
interface swaf_letter_if import swaf_pkg::*;;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  letter_t    letter;

  modport source (output valid, output action, output letter, input ready);
  modport sink   (input valid, input action, input letter, output ready);
endinterface
`default_nettype wire

[rtl/swaf_result_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// swaf_result_if
// Result channel: match flag, window start index and status per transfer.
// ----------------------------------------------------------------------------
interface swaf_result_if import swaf_pkg::*;;
  logic       valid;
  logic       ready;
  logic       found;
  pos_t       start_index;
  logic [1:0] status;

  modport source (output valid, output found, output start_index, output status,
                  input ready);
  modport sink   (input valid, input found, input start_index, input status,
                  output ready);
endinterface
`default_nettype wire

[rtl/sliding_window_anagram_finder_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_anagram_finder_unit
// Streams pattern and text letters and flags windows that are anagrams.
// ----------------------------------------------------------------------------
// The unit takes one item per clock cycle while the result channel does not
// stall it, and returns exactly one result for every item. Items pass through
// three steps: the accept step updates the pattern length, position, fill and
// ring pointer and reads the letter leaving the window from the ring memory;
// the next step reads the letter counts of the incoming and the leaving letter;
// the write-back step updates the counts and the count of agreeing letters and
// registers the result. The count memory read-modify-write of one item overlaps
// the read of the next, and a write bypass at the read port keeps that loop at
// one item per cycle. A clear passes through the steps like any other item; the
// count memories need no clearing pass after reset.
// ----------------------------------------------------------------------------
module sliding_window_anagram_finder_unit import swaf_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  swaf_letter_if.sink   letters,
  swaf_result_if.source results
);

  localparam int OLD_W = CNT_W + 1;

  // Control state; all but the agreeing-letter count update when an item is accepted.
  cnt_t       pattern_length, pattern_length_next;
  pos_t       text_position,  text_position_next;
  ring_addr_t ring_pointer,   ring_pointer_next;
  cnt_t       window_fill,    window_fill_next;
  agree_t     agreeing_letters;

  logic adv0, adv1, adv2, accept, retire;

  // Accept-step decode.
  op_t        dec_op;
  logic [1:0] dec_status;
  logic       dec_evict, dec_win_full, ring_we, letter_ok;
  pos_t       dec_start;
  logic [POSITION_BITS:0] pos_inc;
  logic [OLD_W-1:0]       old_sum;
  ring_addr_t             old_addr;

  letter_t ring_mem [PATTERN_MAX];
  letter_t ring_rd;

  logic       s1_v, s1_evict, s1_win_full;
  op_t        s1_op;
  sym_t       s1_sym;
  pos_t       s1_start;
  logic [1:0] s1_status;

  logic       s2_v, s2_evict, s2_win_full;
  op_t        s2_op;
  sym_t       s2_sym, s2_osym;
  pos_t       s2_start;
  logic [1:0] s2_status;

  count_rd_t rd_req;
  count_wr_t wr_req;
  cnt_t      add_s, add_o;
  pat_rem_t  pr_s, pr_o;
  cnt_t      win_s, win_o;
  logic      same_letter;
  logic [1:0] inc, dec;
  agree_t    agree_calc;
  logic      found_calc;

  assign adv2   = !results.valid || results.ready;
  assign adv1   = !s2_v || adv2;
  assign adv0   = !s1_v || adv1;
  assign letters.ready = adv0;
  assign accept = letters.valid && adv0;
  assign retire = s2_v && adv2;

  assign letter_ok = letters.letter < LETTER_W'(ALPHABET);
  assign pos_inc   = (POSITION_BITS + 1)'(text_position) + 1'b1;

  // Ring slot of the letter that leaves the window.
  always_comb begin
    old_sum = OLD_W'(ring_pointer) + OLD_W'(PATTERN_MAX) - OLD_W'(pattern_length);
    if (old_sum >= OLD_W'(PATTERN_MAX)) begin
      old_sum = old_sum - OLD_W'(PATTERN_MAX);
    end
    old_addr = old_sum[RING_AW-1:0];
  end

  always_comb begin
    dec_op              = OP_NONE;
    dec_status          = ST_OK;
    dec_evict           = 1'b0;
    dec_win_full        = 1'b0;
    dec_start           = '0;
    ring_we             = 1'b0;
    pattern_length_next = pattern_length;
    text_position_next  = text_position;
    ring_pointer_next   = ring_pointer;
    window_fill_next    = window_fill;
    unique case (letters.action)
      ACT_CLEAR: begin
        dec_op              = OP_CLEAR;
        pattern_length_next = '0;
        text_position_next  = '0;
        ring_pointer_next   = '0;
        window_fill_next    = '0;
      end
      ACT_PATTERN: begin
        if (letter_ok) begin
          if (window_fill != '0 || text_position != '0) begin
            dec_status = ST_PAT_LATE;
          end else if (pattern_length >= CNT_W'(PATTERN_MAX)) begin
            dec_status = ST_PAT_FULL;
          end else begin
            dec_op              = OP_PATTERN;
            pattern_length_next = pattern_length + 1'b1;
          end
        end
      end
      ACT_TEXT: begin
        if (letter_ok) begin
          if (text_position == POS_MAX) begin
            dec_status = ST_POS_SAT;
          end else begin
            text_position_next = text_position + 1'b1;
          end
          if (pattern_length != '0) begin
            dec_op  = OP_TEXT;
            ring_we = 1'b1;
            if (ring_pointer == RING_AW'(PATTERN_MAX - 1)) begin
              ring_pointer_next = '0;
            end else begin
              ring_pointer_next = ring_pointer + 1'b1;
            end
            if (window_fill >= pattern_length) begin
              dec_evict    = 1'b1;
              dec_win_full = (window_fill == pattern_length);
            end else begin
              window_fill_next = window_fill + 1'b1;
              dec_win_full     = (window_fill + 1'b1 == pattern_length);
            end
            if (pos_inc >= (POSITION_BITS + 1)'(pattern_length)) begin
              dec_start = POSITION_BITS'(pos_inc - (POSITION_BITS + 1)'(pattern_length));
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      text_position  <= '0;
      ring_pointer   <= '0;
      window_fill    <= '0;
    end else if (accept) begin
      pattern_length <= pattern_length_next;
      text_position  <= text_position_next;
      ring_pointer   <= ring_pointer_next;
      window_fill    <= window_fill_next;
    end
  end

  // Ring of recent text letters. With a full-length pattern the read and the
  // write hit the same slot, and the read returns the letter being replaced.
  always_ff @(posedge clk) begin
    if (accept) begin
      ring_rd <= ring_mem[old_addr];
    end
    if (accept && ring_we) begin
      ring_mem[ring_pointer] <= letters.letter;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv0) begin
      s1_v <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op       <= dec_op;
      s1_sym      <= letters.letter[SYM_W-1:0];
      s1_evict    <= dec_evict;
      s1_win_full <= dec_win_full;
      s1_start    <= dec_start;
      s1_status   <= dec_status;
    end
  end

  always_comb begin
    rd_req.en    = adv1;
    rd_req.addr0 = s1_sym;
    rd_req.addr1 = s1_evict ? ring_rd[SYM_W-1:0] : s1_sym;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (adv1) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s2_op       <= s1_op;
      s2_sym      <= rd_req.addr0;
      s2_osym     <= rd_req.addr1;
      s2_evict    <= s1_evict;
      s2_win_full <= s1_win_full;
      s2_start    <= s1_start;
      s2_status   <= s1_status;
    end
  end

  swaf_count_ram u_count_ram (
    .clk  (clk),
    .rst  (rst),
    .rd   (rd_req),
    .wr   (wr_req),
    .add0 (add_s),
    .add1 (add_o),
    .pr0  (pr_s),
    .pr1  (pr_o)
  );

  // Window count is letters in minus letters out; both wrap together.
  assign win_s       = add_s - pr_s.rem;
  assign win_o       = add_o - pr_o.rem;
  assign same_letter = s2_evict && (s2_osym == s2_sym);

  always_comb begin
    inc = '0;
    dec = '0;
    case (s2_op)
      OP_PATTERN: begin
        if (pr_s.pat == '0) begin
          dec = 2'd1;
        end
      end
      OP_TEXT: begin
        // A letter that leaves and enters at once leaves the agreement as is.
        if (s2_evict && !same_letter) begin
          if (win_o == pr_o.pat) begin
            dec = dec + 2'd1;
          end
          if (win_o - 1'b1 == pr_o.pat) begin
            inc = inc + 2'd1;
          end
        end
        if (!same_letter) begin
          if (win_s == pr_s.pat) begin
            dec = dec + 2'd1;
          end
          if (win_s + 1'b1 == pr_s.pat) begin
            inc = inc + 2'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (s2_op == OP_CLEAR) begin
      agree_calc = AGREE_W'(ALPHABET);
    end else begin
      agree_calc = agreeing_letters + AGREE_W'(inc) - AGREE_W'(dec);
    end
    found_calc = s2_win_full && (agree_calc == AGREE_W'(ALPHABET));
  end

  always_comb begin
    wr_req.clr      = retire && (s2_op == OP_CLEAR);
    wr_req.add_we   = retire && (s2_op == OP_TEXT);
    wr_req.add_addr = s2_sym;
    wr_req.add_data = add_s + 1'b1;
    wr_req.pr_we    = retire && ((s2_op == OP_PATTERN) || (s2_op == OP_TEXT && s2_evict));
    if (s2_op == OP_PATTERN) begin
      wr_req.pr_addr     = s2_sym;
      wr_req.pr_data.pat = pr_s.pat + 1'b1;
      wr_req.pr_data.rem = pr_s.rem;
    end else begin
      wr_req.pr_addr     = s2_osym;
      wr_req.pr_data.pat = pr_o.pat;
      wr_req.pr_data.rem = pr_o.rem + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      agreeing_letters <= AGREE_W'(ALPHABET);
    end else if (retire) begin
      agreeing_letters <= agree_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (adv2) begin
      results.valid <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (retire) begin
      results.found       <= found_calc;
      results.start_index <= found_calc ? s2_start : '0;
      results.status      <= s2_status;
    end
  end

endmodule
`default_nettype wire

[rtl/swaf_count_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// swaf_count_ram
// Letter count memories with two read ports, write bypass and valid bits.
// ----------------------------------------------------------------------------
module swaf_count_ram import swaf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  count_rd_t rd,
  input  count_wr_t wr,
  output cnt_t      add0,
  output cnt_t      add1,
  output pat_rem_t  pr0,
  output pat_rem_t  pr1
);

  // Letters that entered the window, counted modulo the counter width.
  cnt_t     add_mem [ALPHABET];
  pat_rem_t pr_mem  [ALPHABET];
  logic [ALPHABET-1:0] add_vld;
  logic [ALPHABET-1:0] pr_vld;

  cnt_t     add0_raw, add1_raw;
  pat_rem_t pr0_raw, pr1_raw;
  logic     add0_vld, add1_vld, pr0_vld, pr1_vld;
  logic     add0_hit, add1_hit, pr0_hit, pr1_hit;
  cnt_t     add_byp;
  pat_rem_t pr_byp;
  logic     clr_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      add_vld <= '0;
      pr_vld  <= '0;
    end else if (wr.clr) begin
      add_vld <= '0;
      pr_vld  <= '0;
    end else begin
      if (wr.add_we) begin
        add_vld[wr.add_addr] <= 1'b1;
      end
      if (wr.pr_we) begin
        pr_vld[wr.pr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.add_we) begin
      add_mem[wr.add_addr] <= wr.add_data;
    end
    if (wr.pr_we) begin
      pr_mem[wr.pr_addr] <= wr.pr_data;
    end
  end

  // A write that lands on the same edge as a read is caught here, so the
  // read port always sees the most recent value.
  always_ff @(posedge clk) begin
    if (rd.en) begin
      add0_raw <= add_mem[rd.addr0];
      add1_raw <= add_mem[rd.addr1];
      pr0_raw  <= pr_mem[rd.addr0];
      pr1_raw  <= pr_mem[rd.addr1];
      add0_vld <= add_vld[rd.addr0];
      add1_vld <= add_vld[rd.addr1];
      pr0_vld  <= pr_vld[rd.addr0];
      pr1_vld  <= pr_vld[rd.addr1];
      add0_hit <= wr.add_we && (wr.add_addr == rd.addr0);
      add1_hit <= wr.add_we && (wr.add_addr == rd.addr1);
      pr0_hit  <= wr.pr_we && (wr.pr_addr == rd.addr0);
      pr1_hit  <= wr.pr_we && (wr.pr_addr == rd.addr1);
      add_byp  <= wr.add_data;
      pr_byp   <= wr.pr_data;
      clr_seen <= wr.clr;
    end
  end

  always_comb begin
    add0 = clr_seen ? '0 : add0_hit ? add_byp : add0_vld ? add0_raw : '0;
    add1 = clr_seen ? '0 : add1_hit ? add_byp : add1_vld ? add1_raw : '0;
    pr0  = clr_seen ? '0 : pr0_hit  ? pr_byp  : pr0_vld  ? pr0_raw  : '0;
    pr1  = clr_seen ? '0 : pr1_hit  ? pr_byp  : pr1_vld  ? pr1_raw  : '0;
  end

endmodule
`default_nettype wire

[verif/swaf_match_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swaf_match_checker
// Watches both channels of the anagram finder, predicts the result of every
// accepted letter item and compares each result transfer field by field.
// ----------------------------------------------------------------------------
module swaf_match_checker import swaf_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  swaf_letter_if letters,
  swaf_result_if results,
  output int     errors,
  output int     pending,
  output int     checked,
  output int     hits,
  output int     rejects,
  output int     saturated
);

  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    logic       found;
    pos_t       start_index;
    logic [1:0] status;
  } outcome_t;

  // Predictor state.
  cnt_t       pat_hist [ALPHABET];
  cnt_t       win_hist [ALPHABET];
  agree_t     agree;
  cnt_t       pat_len;
  pos_t       text_pos;
  letter_t    ring [PATTERN_MAX];
  ring_addr_t wr_slot;
  cnt_t       fill;

  outcome_t   due_q [$];

  initial begin
    errors    = 0;
    pending   = 0;
    checked   = 0;
    hits      = 0;
    rejects   = 0;
    saturated = 0;
  end

  task automatic report(string msg);
    if (errors < PRINT_LIMIT) $display("%0t ns: MISMATCH %s", $time, msg);
    errors++;
  endtask

  function automatic void clear_search();
    for (int i = 0; i < ALPHABET; i++) begin
      pat_hist[i] = '0;
      win_hist[i] = '0;
    end
    for (int i = 0; i < PATTERN_MAX; i++) ring[i] = '0;
    agree    = agree_t'(ALPHABET);
    pat_len  = '0;
    text_pos = '0;
    wr_slot  = '0;
    fill     = '0;
  endfunction

  // Moves one window count and keeps the count of agreeing letters true.
  function automatic void shift_window(letter_t s, bit up);
    if (win_hist[s] == pat_hist[s]) agree--;
    if (up) win_hist[s]++;
    else if (win_hist[s] != 0) win_hist[s]--;
    if (win_hist[s] == pat_hist[s]) agree++;
  endfunction

  function automatic outcome_t predict_match(logic [1:0] act, letter_t ltr);
    outcome_t    o;
    int unsigned pos;
    ring_addr_t  oldest;
    o = '0;
    if (act == ACT_CLEAR) begin
      clear_search();
    end else if ((act != ACT_PATTERN && act != ACT_TEXT) || ltr >= ALPHABET) begin
      // Unused action or a letter outside the alphabet leaves everything alone.
    end else if (act == ACT_PATTERN) begin
      if (fill != 0 || text_pos != 0) begin
        o.status = ST_PAT_LATE;
      end else if (pat_len >= PATTERN_MAX) begin
        o.status = ST_PAT_FULL;
      end else begin
        // The window is empty, so only a fresh letter stops agreeing.
        if (pat_hist[ltr] == 0) agree--;
        pat_hist[ltr]++;
        pat_len++;
      end
    end else begin
      pos = 32'(text_pos);
      if (text_pos == POS_MAX) o.status = ST_POS_SAT;
      else text_pos++;
      if (pat_len != 0) begin
        if (fill >= pat_len) begin
          oldest = wr_slot - ring_addr_t'(pat_len);
          shift_window(ring[oldest], 1'b0);
        end else begin
          fill++;
        end
        shift_window(ltr, 1'b1);
        ring[wr_slot] = ltr;
        wr_slot++;
        if (fill == pat_len && agree == ALPHABET) begin
          o.found = 1'b1;
          if (pos + 1 >= pat_len) o.start_index = pos_t'(pos + 1 - pat_len);
        end
      end
    end
    return o;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      clear_search();
      due_q.delete();
    end else begin
      if (results.valid === 1'b1 && results.ready === 1'b1) begin
        checked++;
        if (results.found === 1'b1) hits++;
        if (results.status === ST_PAT_FULL || results.status === ST_PAT_LATE) rejects++;
        if (results.status === ST_POS_SAT) saturated++;
        if (due_q.size() == 0) begin
          report($sformatf("result with no item outstanding: found %b start %0d status %0d",
                           results.found, results.start_index, results.status));
        end else begin
          want = due_q.pop_front();
          if (results.found !== want.found)
            report($sformatf("found: got %b, expected %b", results.found, want.found));
          if (results.start_index !== want.start_index)
            report($sformatf("start_index: got %0d, expected %0d",
                             results.start_index, want.start_index));
          if (results.status !== want.status)
            report($sformatf("status: got %0d, expected %0d", results.status, want.status));
        end
      end
      if (letters.valid === 1'b1 && letters.ready === 1'b1)
        due_q.push_back(predict_match(letters.action, letters.letter));
    end
    pending = due_q.size();
  end

endmodule

[verif/sliding_window_anagram_finder_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_anagram_finder_unit_tb
// Drives pattern and text letters into the anagram finder with random gaps
// and result stalls; a checker beside the unit predicts and compares results.
// ----------------------------------------------------------------------------
module sliding_window_anagram_finder_unit_tb;
  import swaf_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int         ITEM_GOAL  = 1600;

  logic clk = 1'b0;
  logic rst = 1'b1;

  swaf_letter_if letters_if ();
  swaf_result_if results_if ();

  int errors, pending, checked, hits, rejects, saturated;
  int sent;
  bit calm;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sliding_window_anagram_finder_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .letters (letters_if),
    .results (results_if)
  );

  swaf_match_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .letters   (letters_if),
    .results   (results_if),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked),
    .hits      (hits),
    .rejects   (rejects),
    .saturated (saturated)
  );

  function automatic int pick_gap();
    return calm ? 0 : $urandom_range(0, 5);
  endfunction

  // Presents one item after a random gap and returns at the edge of its transfer.
  task automatic send_item(logic [1:0] act, letter_t ltr);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      letters_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    letters_if.valid  <= 1'b1;
    letters_if.action <= act;
    letters_if.letter <= ltr;
    do @(posedge clk); while (letters_if.ready !== 1'b1);
    sent++;
  endtask

  // A pattern followed by text drawn mostly from the pattern's own letters,
  // with some unused actions, bad letters and late pattern letters mixed in.
  task automatic run_search(int plen, int tlen, int span, bit fresh);
    letter_t     pat [$];
    int unsigned r;
    if (fresh) send_item(ACT_CLEAR, letter_t'($urandom_range(0, 31)));
    for (int i = 0; i < plen; i++) begin
      pat.push_back(letter_t'($urandom_range(0, span - 1)));
      send_item(ACT_PATTERN, pat[$]);
    end
    for (int i = 0; i < tlen; i++) begin
      r = $urandom_range(0, 99);
      if (r < 4) send_item(ACT_UNUSED, letter_t'($urandom_range(0, 31)));
      else if (r < 8)
        send_item(2'($urandom_range(1, 2)), letter_t'($urandom_range(ALPHABET, 31)));
      else if (r < 11) send_item(ACT_PATTERN, letter_t'($urandom_range(0, ALPHABET - 1)));
      else if (r < 75 && pat.size() > 0)
        send_item(ACT_TEXT, pat[$urandom_range(0, pat.size() - 1)]);
      else send_item(ACT_TEXT, letter_t'($urandom_range(0, span - 1)));
    end
  endtask

  // Result side: random stalls before each transfer.
  initial begin
    int stall;
    results_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        results_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      results_if.ready <= 1'b1;
      do @(posedge clk); while (results_if.valid !== 1'b1);
    end
  end

  initial begin
    int plen, span, r, drain;
    letters_if.valid  <= 1'b0;
    letters_if.action <= ACT_CLEAR;
    letters_if.letter <= '0;
    sent = 0;
    calm = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty pattern, repeated pattern letter, ignored items,
    // overlapping matches, a late pattern letter and a clear with all ones.
    send_item(ACT_TEXT, letter_t'(0));
    send_item(ACT_CLEAR, letter_t'(0));
    send_item(ACT_PATTERN, letter_t'(0));
    send_item(ACT_PATTERN, letter_t'(25));
    send_item(ACT_PATTERN, letter_t'(0));
    send_item(ACT_UNUSED, letter_t'(31));
    send_item(ACT_PATTERN, letter_t'(26));
    send_item(ACT_TEXT, letter_t'(31));
    send_item(ACT_TEXT, letter_t'(25));
    send_item(ACT_TEXT, letter_t'(0));
    send_item(ACT_TEXT, letter_t'(0));
    send_item(ACT_TEXT, letter_t'(25));
    send_item(ACT_TEXT, letter_t'(1));
    send_item(ACT_PATTERN, letter_t'(3));
    send_item(ACT_CLEAR, letter_t'(31));

    // A pattern longer than the window can hold.
    run_search(PATTERN_MAX + 2, PATTERN_MAX + 30, 2, 1'b1);

    while (sent < ITEM_GOAL) begin
      if ($urandom_range(0, 4) == 0) calm = !calm;
      r = $urandom_range(0, 99);
      if (r < 5) plen = 0;
      else if (r < 80) plen = $urandom_range(1, 5);
      else if (r < 95) plen = $urandom_range(6, 20);
      else plen = $urandom_range(PATTERN_MAX - 4, PATTERN_MAX + 2);
      span = ($urandom_range(0, 2) == 0) ? $urandom_range(2, ALPHABET) : $urandom_range(2, 4);
      run_search(plen, plen + $urandom_range(4, 40), span, $urandom_range(0, 9) != 0);
    end
    letters_if.valid <= 1'b0;
    calm = 1'b0;

    drain = 0;
    while (pending != 0 && drain < 2000) begin
      @(posedge clk);
      drain++;
    end
    repeat (12) @(posedge clk);

    $display("Sent %0d items with random gaps and stalls; %0d results checked.",
             sent, checked);
    $display("Seen %0d anagram matches, %0d rejected pattern letters, %0d saturated positions.",
             hits, rejects, saturated);
    if (pending != 0) $display("%0d expected results never arrived.", pending);
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding.", pending);
    $display("Some tests failed");
    $finish;
  end

endmodule
